// ===== design/wph_pkg.sv =====
// Package for the WAV PCM header parser: word types, tag constants,
// result and error codes, and a helper that builds an error word.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package wph_pkg;

  // Tags as they appear in the little-endian window, first byte lowest.
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;  // "RIFF"
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;  // "WAVE"
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;  // "fmt "
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;  // "data"

  localparam logic [31:0] FMT_BLOCK_SIZE = 32'd16;
  localparam logic [15:0] PCM_CODE       = 16'd1;

  // Result kinds.
  localparam logic [1:0] KIND_FORMAT = 2'd0;
  localparam logic [1:0] KIND_DATA   = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  // Error codes.
  localparam logic [2:0] ERR_RIFF       = 3'd0;
  localparam logic [2:0] ERR_WAVE       = 3'd1;
  localparam logic [2:0] ERR_FMT_TAG    = 3'd2;
  localparam logic [2:0] ERR_FMT_SIZE   = 3'd3;
  localparam logic [2:0] ERR_COMP       = 3'd4;
  localparam logic [2:0] ERR_NO_DATA    = 3'd5;
  localparam logic [2:0] ERR_ZERO_FRAME = 3'd6;
  localparam logic [2:0] ERR_TRUNCATED  = 3'd7;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       end_of_file;
  } wph_in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] sample_rate;
    logic [15:0] num_channels;
    logic [15:0] frame_bytes;
    logic [31:0] frame_count;
    logic [7:0]  data_byte;
    logic [2:0]  error_code;
    logic        last_data;
  } wph_out_t;

  // Error word: every field but the kind and the code is zero.
  function automatic wph_out_t error_word(input logic [2:0] code);
    wph_out_t w;
    w            = '0;
    w.kind       = KIND_ERROR;
    w.error_code = code;
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== design/wav_pcm_header_parser_core.sv =====
// Top level of the WAV PCM header parser: byte-wide header sequencer,
// bit-serial divider for the frame count, and the output register.
// Depends on wph_pkg.
`timescale 1ns / 1ps
`default_nettype none

// The parser takes a WAV file one byte per input word and checks the RIFF,
// WAVE and fmt tags, a 16-byte fmt block and PCM compression code 1. It
// captures the channel count, sample rate and frame size, then slides a
// four-byte window to find the data tag, giving up once the window start
// reaches the RIFF size. After the data size it emits one format word whose
// frame count is the data size divided by the frame size, and then passes
// each payload byte through as a data word, flagging the last one. Errors
// produce one error word, after which bytes are ignored until the word
// marked end_of_file, which always returns the parser to its reset state.
// The sequencer handles each byte as it arrives, except the last byte of the
// data size field: that word starts a restoring divider that retires one
// quotient bit per cycle, and the input stays not ready until the format word
// lands in the output register. The output register holds one word; while the
// divider is idle, a new input word is taken in the same cycle that the held
// word is taken by the consumer.
module wav_pcm_header_parser_core (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              in_valid_i,
  output logic             in_ready_o,
  input  wire wph_pkg::wph_in_t in_i,
  output logic             out_valid_o,
  input  wire              out_ready_i,
  output wph_pkg::wph_out_t out_o
);

  typedef enum logic [3:0] {
    PH_RIFF    = 4'd0,
    PH_SIZE    = 4'd1,
    PH_WAVE    = 4'd2,
    PH_FMT     = 4'd3,
    PH_FMTSIZE = 4'd4,
    PH_COMP    = 4'd5,
    PH_CHAN    = 4'd6,
    PH_RATE    = 4'd7,
    PH_BPS     = 4'd8,
    PH_ALIGN   = 4'd9,
    PH_BITS    = 4'd10,
    PH_SEARCH  = 4'd11,
    PH_DSIZE   = 4'd12,
    PH_PAYLOAD = 4'd13,
    PH_IDLE    = 4'd14
  } phase_e;

  // Parser state.
  phase_e      phase_q, phase_d;
  logic [31:0] offset_q, offset_d;
  logic [2:0]  shift_q, shift_d;
  logic [31:0] window_q, window_d;
  logic [31:0] riff_size_q, riff_size_d;
  logic [31:0] rate_q, rate_d;
  logic [15:0] chan_q, chan_d;
  logic [15:0] frame_q, frame_d;
  logic [31:0] left_q, left_d;

  // Divider and output register. The divisor is the frame_bytes field of
  // the staged output word.
  logic        div_busy_q, div_busy_d;
  logic [4:0]  div_cnt_q, div_cnt_d;
  logic [31:0] div_quo_q, div_quo_d;
  logic [15:0] div_rem_q, div_rem_d;
  logic        out_valid_q, out_valid_d;
  wph_pkg::wph_out_t out_q, out_d;

  logic in_fire;

  assign in_ready_o  = !div_busy_q && (!out_valid_q || out_ready_i);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_comb begin
    logic [31:0]       win;
    logic [15:0]       half;
    logic [2:0]        fs;
    phase_e            ph;
    logic [31:0]       pl;
    logic [16:0]       rem_sh;
    logic [16:0]       rem_sub;
    logic              res_en;
    logic              start_div;
    wph_pkg::wph_out_t res;

    phase_d     = phase_q;
    offset_d    = offset_q;
    shift_d     = shift_q;
    window_d    = window_q;
    riff_size_d = riff_size_q;
    rate_d      = rate_q;
    chan_d      = chan_q;
    frame_d     = frame_q;
    left_d      = left_q;
    div_busy_d  = div_busy_q;
    div_cnt_d   = div_cnt_q;
    div_quo_d   = div_quo_q;
    div_rem_d   = div_rem_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;

    win       = {in_i.byte_in, window_q[31:8]};
    half      = win[31:16];
    fs        = shift_q;
    ph        = phase_q;
    pl        = left_q;
    res_en    = 1'b0;
    start_div = 1'b0;
    res       = '0;

    // One restoring step per cycle: shift in the next dividend bit and
    // subtract the divisor when it fits.
    rem_sh  = {div_rem_q, div_quo_q[31]};
    rem_sub = rem_sh - {1'b0, out_q.frame_bytes};
    if (div_busy_q) begin
      if (!rem_sub[16]) begin
        div_rem_d = rem_sub[15:0];
        div_quo_d = {div_quo_q[30:0], 1'b1};
      end else begin
        div_rem_d = rem_sh[15:0];
        div_quo_d = {div_quo_q[30:0], 1'b0};
      end
      div_cnt_d = div_cnt_q + 5'd1;
      if (div_cnt_q == 5'd31) begin
        div_busy_d        = 1'b0;
        out_d.frame_count = div_quo_d;
        out_valid_d       = 1'b1;
      end
    end

    if (in_fire) begin
      if (offset_q != 32'hFFFF_FFFF) begin
        offset_d = offset_q + 32'd1;
      end
      window_d = win;
      if (phase_q < PH_PAYLOAD && shift_q < 3'd4) begin
        fs = shift_q + 3'd1;
      end

      case (phase_q)
        PH_RIFF: begin
          if (fs == 3'd4) begin
            if (win != wph_pkg::TAG_RIFF) begin
              res_en = 1'b1;
              res    = wph_pkg::error_word(wph_pkg::ERR_RIFF);
              ph     = PH_IDLE;
            end else begin
              ph = PH_SIZE;
            end
            fs = 3'd0;
          end
        end
        PH_SIZE: begin
          if (fs == 3'd4) begin
            riff_size_d = win;
            ph          = PH_WAVE;
            fs          = 3'd0;
          end
        end
        PH_WAVE: begin
          if (fs == 3'd4) begin
            if (win != wph_pkg::TAG_WAVE) begin
              res_en = 1'b1;
              res    = wph_pkg::error_word(wph_pkg::ERR_WAVE);
              ph     = PH_IDLE;
            end else begin
              ph = PH_FMT;
            end
            fs = 3'd0;
          end
        end
        PH_FMT: begin
          if (fs == 3'd4) begin
            if (win != wph_pkg::TAG_FMT) begin
              res_en = 1'b1;
              res    = wph_pkg::error_word(wph_pkg::ERR_FMT_TAG);
              ph     = PH_IDLE;
            end else begin
              ph = PH_FMTSIZE;
            end
            fs = 3'd0;
          end
        end
        PH_FMTSIZE: begin
          if (fs == 3'd4) begin
            if (win != wph_pkg::FMT_BLOCK_SIZE) begin
              res_en = 1'b1;
              res    = wph_pkg::error_word(wph_pkg::ERR_FMT_SIZE);
              ph     = PH_IDLE;
            end else begin
              ph = PH_COMP;
            end
            fs = 3'd0;
          end
        end
        PH_COMP: begin
          if (fs == 3'd2) begin
            if (half != wph_pkg::PCM_CODE) begin
              res_en = 1'b1;
              res    = wph_pkg::error_word(wph_pkg::ERR_COMP);
              ph     = PH_IDLE;
            end else begin
              ph = PH_CHAN;
            end
            fs = 3'd0;
          end
        end
        PH_CHAN: begin
          if (fs == 3'd2) begin
            chan_d = half;
            ph     = PH_RATE;
            fs     = 3'd0;
          end
        end
        PH_RATE: begin
          if (fs == 3'd4) begin
            rate_d = win;
            ph     = PH_BPS;
            fs     = 3'd0;
          end
        end
        PH_BPS: begin
          if (fs == 3'd4) begin
            ph = PH_ALIGN;
            fs = 3'd0;
          end
        end
        PH_ALIGN: begin
          if (fs == 3'd2) begin
            frame_d = half;
            ph      = PH_BITS;
            fs      = 3'd0;
          end
        end
        PH_BITS: begin
          if (fs == 3'd2) begin
            ph = PH_SEARCH;
            fs = 3'd0;
          end
        end
        PH_SEARCH: begin
          // The window is tested once it holds four fresh bytes; its start
          // offset is three below the offset of the newest byte.
          if (fs == 3'd4 && offset_q >= 32'd3) begin
            if (win == wph_pkg::TAG_DATA) begin
              ph = PH_DSIZE;
              fs = 3'd0;
            end else if ((offset_q - 32'd3) >= riff_size_q) begin
              res_en = 1'b1;
              res    = wph_pkg::error_word(wph_pkg::ERR_NO_DATA);
              ph     = PH_IDLE;
              fs     = 3'd0;
            end
          end
        end
        PH_DSIZE: begin
          if (fs == 3'd4) begin
            left_d = win;
            fs     = 3'd0;
            if (frame_q == 16'd0) begin
              res_en = 1'b1;
              res    = wph_pkg::error_word(wph_pkg::ERR_ZERO_FRAME);
              ph     = PH_IDLE;
            end else if (in_i.end_of_file && win != 32'd0) begin
              res_en = 1'b1;
              res    = wph_pkg::error_word(wph_pkg::ERR_TRUNCATED);
              ph     = PH_IDLE;
            end else begin
              // The format word is completed by the divider.
              start_div = 1'b1;
              ph        = (win != 32'd0) ? PH_PAYLOAD : PH_IDLE;
            end
          end
        end
        PH_PAYLOAD: begin
          if (pl != 32'd0) begin
            pl = pl - 32'd1;
          end
          left_d = pl;
          res_en = 1'b1;
          if (in_i.end_of_file && pl != 32'd0) begin
            res = wph_pkg::error_word(wph_pkg::ERR_TRUNCATED);
            ph  = PH_IDLE;
            fs  = 3'd0;
          end else begin
            res.kind      = wph_pkg::KIND_DATA;
            res.data_byte = in_i.byte_in;
            res.last_data = (pl == 32'd0);
            if (pl == 32'd0) begin
              ph = PH_IDLE;
              fs = 3'd0;
            end
          end
        end
        default: begin
        end
      endcase

      phase_d = ph;
      shift_d = fs;

      // A stream that ends before the payload is complete is truncated,
      // unless this byte already produced a word of its own.
      if (in_i.end_of_file && !res_en && !start_div && ph != PH_IDLE) begin
        res_en = 1'b1;
        res    = wph_pkg::error_word(wph_pkg::ERR_TRUNCATED);
      end

      if (res_en) begin
        out_valid_d = 1'b1;
        out_d       = res;
      end

      if (start_div) begin
        div_busy_d         = 1'b1;
        div_cnt_d          = 5'd0;
        div_quo_d          = win;
        div_rem_d          = 16'd0;
        out_d              = '0;
        out_d.kind         = wph_pkg::KIND_FORMAT;
        out_d.sample_rate  = rate_q;
        out_d.num_channels = chan_q;
        out_d.frame_bytes  = frame_q;
      end

      // The final byte of the file returns the parser to its reset state.
      if (in_i.end_of_file) begin
        phase_d     = PH_RIFF;
        offset_d    = 32'd0;
        shift_d     = 3'd0;
        window_d    = 32'd0;
        riff_size_d = 32'd0;
        rate_d      = 32'd0;
        chan_d      = 16'd0;
        frame_d     = 16'd0;
        left_d      = 32'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_RIFF;
      offset_q    <= 32'd0;
      shift_q     <= 3'd0;
      window_q    <= 32'd0;
      riff_size_q <= 32'd0;
      rate_q      <= 32'd0;
      chan_q      <= 16'd0;
      frame_q     <= 16'd0;
      left_q      <= 32'd0;
      div_busy_q  <= 1'b0;
      div_cnt_q   <= 5'd0;
      div_quo_q   <= 32'd0;
      div_rem_q   <= 16'd0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      phase_q     <= phase_d;
      offset_q    <= offset_d;
      shift_q     <= shift_d;
      window_q    <= window_d;
      riff_size_q <= riff_size_d;
      rate_q      <= rate_d;
      chan_q      <= chan_d;
      frame_q     <= frame_d;
      left_q      <= left_d;
      div_busy_q  <= div_busy_d;
      div_cnt_q   <= div_cnt_d;
      div_quo_q   <= div_quo_d;
      div_rem_q   <= div_rem_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

endmodule

`default_nettype wire
